// ===== sv/tcw_pkg.sv =====
// Shared constants and types for the text console writer.
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int ADDR_W   = $clog2(CELL_COUNT);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int ROW_W    = $clog2(ROWS);
    localparam int CURSOR_W = 11;
    localparam int RIDX_W   = 11;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = CHAR_W + ATTR_W;

    typedef logic [CELL_W-1:0] cell_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [ATTR_W-1:0] attr_t;

    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam char_t CH_NEWLINE   = 8'd10;
    localparam char_t CH_BACKSPACE = 8'd8;
    localparam char_t CH_SPACE     = 8'h20;
    localparam attr_t SCROLL_ATTR  = 8'h0F;
    localparam attr_t COLOR_RESET  = 8'h07;
    localparam cell_t RESET_CELL   = 16'h0720;

endpackage

// ===== sv/tcw_if.sv =====
// Valid/ready channel interfaces for the text console writer.
interface tcw_req_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    char_t             char_code;
    logic [RIDX_W-1:0] read_index;

    modport source (output valid, func, char_code, read_index, input ready);
    modport sink   (input valid, func, char_code, read_index, output ready);
endinterface

interface tcw_rsp_if;
    import tcw_pkg::*;

    logic                valid;
    logic                ready;
    logic [CURSOR_W-1:0] cursor_index;
    cell_t               cell_data;

    modport source (output valid, cursor_index, cell_data, input ready);
    modport sink   (input valid, cursor_index, cell_data, output ready);
endinterface

// ===== sv/text_console_writer.sv =====
// Text console writer: screen memory, cursor and scroll sequencer.
//
// Usage:
//   req channel: one transfer per item. func selects put character or read
//   cell; char_code is the character (newline and backspace edit the cursor);
//   read_index selects the cell for a read.
//   rsp channel: one transfer per item with the cursor index after the item
//   and, for an in-range read, the cell (attribute in the high byte), else zero.
//   cfg_wr_en / cfg_wr_data write the text color attribute at a clock edge.
// Timing: req.ready is high only while the sequencer is idle. A put item
//   goes through EXEC to its result register; a read goes through EXEC and
//   RDWAIT (the memory read), and an out-of-range read skips RDWAIT. A new item
//   is accepted only after the result of the last one is registered.
//   A put that passes the last row adds a scroll (states SCSTRT, SCROLL):
//   one cell copy per cycle through the single write port.
// Reset: cursor goes to the top left, color to 0x07, and a clearing pass
//   writes 0x0720 to every cell with req.ready low.
// Stall: the result waits in its register while rsp.ready is low; a finished
//   item can be parked there while the next one is accepted and worked on.
module text_console_writer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  tcw_pkg::attr_t        cfg_wr_data,
    tcw_req_if.sink               req,
    tcw_rsp_if.source             rsp
);
    import tcw_pkg::*;

    localparam int CIW = (ADDR_W > CURSOR_W) ? ADDR_W : CURSOR_W;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_SCSTRT = 3'd4;
    localparam logic [2:0] S_SCROLL = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    cell_t mem [CELL_COUNT];

    logic [2:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    attr_t               color_reg, color_next;
    logic                func_reg, func_next;
    char_t               char_reg, char_next;
    logic [RIDX_W-1:0]   ridx_reg, ridx_next;
    cell_t               data_reg, data_next;
    logic                out_valid_reg, out_valid_next;
    logic [CURSOR_W-1:0] out_cursor_reg, out_cursor_next;
    cell_t               out_data_reg, out_data_next;
    cell_t               rdata_reg;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    cell_t               mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;

    logic [ROW_W:0]      nrow;
    logic [COL_W:0]      ncol;
    logic [ROW_W-1:0]    wrow;
    logic [COL_W-1:0]    wcol;
    logic                put_we;
    cell_t               put_cell;
    logic [ADDR_W:0]     rd_ahead;
    logic [CIW-1:0]      cursor_full;

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.cursor_index = out_cursor_reg;
    assign rsp.cell_data    = out_data_reg;

    assign cursor_full = CIW'(row_reg) * CIW'(COLUMNS) + CIW'(col_reg);
    assign rd_ahead    = (ADDR_W+1)'(cnt_reg) + (ADDR_W+1)'(COLUMNS + 1);

    // put item: cursor edit and cell write position
    always_comb
    begin
        nrow     = {1'b0, row_reg};
        ncol     = {1'b0, col_reg};
        wrow     = row_reg;
        wcol     = col_reg;
        put_we   = 1'b0;
        put_cell = {color_reg, char_reg};
        if (char_reg == CH_NEWLINE)
        begin
            ncol = '0;
            nrow = {1'b0, row_reg} + 1'b1;
        end
        else if (char_reg == CH_BACKSPACE)
        begin
            put_we   = 1'b1;
            put_cell = {color_reg, CH_SPACE};
            if (col_reg != '0)
            begin
                wcol = col_reg - 1'b1;
            end
            else if (row_reg != '0)
            begin
                wrow = row_reg - 1'b1;
                wcol = COL_W'(COLUMNS - 1);
            end
            nrow = {1'b0, wrow};
            ncol = {1'b0, wcol};
        end
        else
        begin
            put_we = 1'b1;
            ncol   = {1'b0, col_reg} + 1'b1;
        end
        if (ncol == (COL_W+1)'(COLUMNS))
        begin
            ncol = '0;
            nrow = nrow + 1'b1;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        color_next      = cfg_wr_en ? cfg_wr_data : color_reg;
        func_next       = func_reg;
        char_next       = char_reg;
        ridx_next       = ridx_reg;
        data_next       = data_reg;
        out_valid_next  = out_valid_reg & ~rsp.ready;
        out_cursor_next = out_cursor_reg;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = cnt_reg;
        mem_wdata       = RESET_CELL;
        mem_raddr       = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next  = req.func;
                    char_next  = req.char_code;
                    ridx_next  = req.read_index;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                data_next = '0;
                if (func_reg == FUNC_READ)
                begin
                    mem_raddr = ADDR_W'(ridx_reg);
                    if ((RIDX_W+1)'(ridx_reg) < (RIDX_W+1)'(CELL_COUNT))
                        state_next = S_RDWAIT;
                    else
                        state_next = S_DONE;
                end
                else
                begin
                    mem_we    = put_we;
                    mem_waddr = ADDR_W'(ADDR_W'(wrow) * ADDR_W'(COLUMNS) + ADDR_W'(wcol));
                    mem_wdata = put_cell;
                    col_next  = ncol[COL_W-1:0];
                    if (nrow == (ROW_W+1)'(ROWS))
                    begin
                        row_next   = ROW_W'(ROWS - 1);
                        state_next = S_SCSTRT;
                    end
                    else
                    begin
                        row_next   = nrow[ROW_W-1:0];
                        state_next = S_DONE;
                    end
                end
            end
            S_RDWAIT:
            begin
                data_next  = rdata_reg;
                state_next = S_DONE;
            end
            S_SCSTRT:
            begin
                mem_raddr  = ADDR_W'(COLUMNS);
                cnt_next   = '0;
                state_next = S_SCROLL;
            end
            S_SCROLL:
            begin
                // copy writes the read data in the cycle after the read; bottom row gets the blank
                mem_we = 1'b1;
                if ((ADDR_W+1)'(cnt_reg) < (ADDR_W+1)'(CELL_COUNT - COLUMNS))
                    mem_wdata = rdata_reg;
                else
                    mem_wdata = {SCROLL_ATTR, CH_SPACE};
                if (rd_ahead < (ADDR_W+1)'(CELL_COUNT))
                    mem_raddr = rd_ahead[ADDR_W-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_cursor_next = cursor_full[CURSOR_W-1:0];
                    out_data_next   = data_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            color_reg     <= COLOR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            color_reg     <= color_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        char_reg       <= char_next;
        ridx_reg       <= ridx_next;
        data_reg       <= data_next;
        out_cursor_reg <= out_cursor_next;
        out_data_reg   <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[mem_raddr];
    end

endmodule
